@@ rtl/assert_macros.svh @@
// ============================================================================
// Assertion macros
// Short forms for the concurrent assertions used by the checker modules.
// ============================================================================
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Expression must hold at every clock edge outside reset.
`define AST_ALWAYS(lbl, clk, rstn, expr) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (expr)) \
        else $error("assertion failed");

// Consequent must hold in the same cycle as the antecedent.
`define AST_IMPLY(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define AST_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ rtl/tkfd_pkg.sv @@
// ============================================================================
// Touch/key frame decoder package
// Shared types, protocol constants and the scancode map.
// ============================================================================
package tkfd_pkg;

    localparam int KEPT_BYTES_DEF = 4;

    localparam logic [7:0] START_BYTE = 8'h02;
    localparam logic [7:0] END_BYTE   = 8'h03;
    localparam logic [3:0] ID_LIMIT   = 4'd14;
    localparam logic [3:0] ID_KEY     = 4'd2;
    localparam logic [3:0] ID_TOUCH   = 4'd3;

    // Reported key codes.
    localparam logic [2:0] KC_RECORD = 3'd0;
    localparam logic [2:0] KC_Q      = 3'd1;
    localparam logic [2:0] KC_UP     = 3'd2;
    localparam logic [2:0] KC_RIGHT  = 3'd3;
    localparam logic [2:0] KC_LEFT   = 3'd4;
    localparam logic [2:0] KC_DOWN   = 3'd5;

    // Parser phases, one-hot.
    typedef enum logic [3:0] {
        PH_HUNT  = 4'b0001,
        PH_HEAD  = 4'b0010,
        PH_DATA  = 4'b0100,
        PH_CLOSE = 4'b1000
    } t_phase;

    typedef struct packed {
        logic       hit;
        logic [2:0] code;
    } t_key_map;

    typedef struct packed {
        logic [3:0]  frame_id;
        logic        key_valid;
        logic [2:0]  key_code;
        logic        key_pressed;
        logic        touch_press;
        logic        position_valid;
        logic [15:0] pos_x;
        logic [15:0] pos_y;
        logic        touch_release;
    } t_result;

    // Maps a raw 7-bit scancode to a reported key code.
    function automatic t_key_map map_key(input logic [6:0] scan);
        t_key_map m;
        m.hit  = 1'b1;
        m.code = KC_RECORD;
        case (scan)
            7'd1: m.code = KC_RECORD;
            7'd4: m.code = KC_Q;
            7'd6: m.code = KC_UP;
            7'd7: m.code = KC_RIGHT;
            7'd8: m.code = KC_LEFT;
            7'd9: m.code = KC_DOWN;
            default: begin
                m.hit  = 1'b0;
                m.code = KC_RECORD;
            end
        endcase
        return m;
    endfunction

endpackage

@@ rtl/touch_key_frame_decoder_core.sv @@
// ============================================================================
// Touch/key frame decoder core
// Parses a byte stream into key and touch events, one result per good frame.
// ============================================================================
// Usage:
// The input channel carries one received serial byte per request
// (i_in_valid / o_in_stall). The output channel carries one decoded event
// per accepted frame (o_out_valid / i_out_stall); bytes that do not close a
// frame produce nothing on the output.
// A byte is taken every cycle while o_in_stall is low: the parser state
// updates in the cycle the byte is accepted, and a closing byte's event is
// registered into the output register, or the skid register if it is held.
// Behind the output register sits a one-entry skid register, so the input
// keeps flowing while an event waits to be taken. Only when both hold an
// event does o_in_stall rise; it is a registered signal.
// Reset (synchronous, active low) returns the parser to hunting for the
// start byte, clears the kept payload bytes and the pen state, and empties
// both output registers.
// ============================================================================
module touch_key_frame_decoder_core
    import tkfd_pkg::*;
#(
    parameter int KEPT_BYTES = KEPT_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_rx_byte,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [3:0]  o_frame_id,
    output logic        o_key_valid,
    output logic [2:0]  o_key_code,
    output logic        o_key_down,
    output logic        o_touch_press,
    output logic        o_position_valid,
    output logic [15:0] o_pos_x,
    output logic [15:0] o_pos_y,
    output logic        o_touch_release
);

    localparam int IDX_W = (KEPT_BYTES > 1) ? $clog2(KEPT_BYTES) : 1;

    // Parser state.
    t_phase      r_phase, n_phase;
    logic [3:0]  r_cur_id, n_cur_id;
    logic [3:0]  r_cur_len, n_cur_len;
    logic [3:0]  r_byte_pos, n_byte_pos;
    logic [7:0]  r_sum, n_sum;
    logic        r_pen, n_pen;
    logic [7:0]  r_store [KEPT_BYTES];

    // Output register and skid register.
    t_result     r_out, r_skid;
    logic        r_out_valid, r_skid_valid;

    logic        in_acc;
    logic        emit;
    logic        store_wr;
    logic        out_free;
    t_result     result;
    t_key_map    km;

    assign in_acc = i_in_valid && !o_in_stall;

    // A payload byte is kept only while it falls inside the store.
    assign store_wr = in_acc && (r_phase == PH_DATA) && (32'(r_byte_pos) < KEPT_BYTES);

    // A closing byte accepts the frame when it is the end marker or the sum.
    assign emit = in_acc && (r_phase == PH_CLOSE)
               && ((i_rx_byte == END_BYTE) || (i_rx_byte == r_sum));

    // Next-state logic for the parser.
    always_comb begin
        n_phase    = r_phase;
        n_cur_id   = r_cur_id;
        n_cur_len  = r_cur_len;
        n_byte_pos = r_byte_pos;
        n_sum      = r_sum;
        n_pen      = r_pen;
        if (in_acc) begin
            case (r_phase)
                PH_HUNT: begin
                    if (i_rx_byte == START_BYTE) begin
                        n_phase = PH_HEAD;
                    end
                end
                PH_HEAD: begin
                    n_cur_id   = i_rx_byte[7:4];
                    n_cur_len  = i_rx_byte[3:0];
                    n_byte_pos = 4'd0;
                    if (i_rx_byte[7:4] >= ID_LIMIT) begin
                        // Reserved ids drop the frame right at the header.
                        n_phase = PH_HUNT;
                    end else begin
                        n_sum   = i_rx_byte;
                        n_phase = (i_rx_byte[3:0] != 4'd0) ? PH_DATA : PH_CLOSE;
                    end
                end
                PH_DATA: begin
                    n_sum      = r_sum + i_rx_byte;
                    n_byte_pos = r_byte_pos + 4'd1;
                    if ((r_byte_pos + 4'd1) == r_cur_len) begin
                        n_phase = PH_CLOSE;
                    end
                end
                PH_CLOSE: begin
                    n_phase = PH_HUNT;
                    // A touch frame leaves the pen down when it carries
                    // coordinates and up when it is empty.
                    if (emit && (r_cur_id == ID_TOUCH)) begin
                        n_pen = (r_cur_len != 4'd0);
                    end
                end
                default: begin
                    n_phase = PH_HUNT;
                end
            endcase
        end
    end

    // Event built from the completed frame. The kept bytes still hold values
    // from earlier frames where this frame was short.
    always_comb begin
        km     = map_key(r_store[0][6:0]);
        result = '0;
        result.frame_id = r_cur_id;
        if (r_cur_id == ID_KEY) begin
            if (km.hit) begin
                result.key_valid   = 1'b1;
                result.key_code    = km.code;
                result.key_pressed = !r_store[0][7];
            end
        end else if (r_cur_id == ID_TOUCH) begin
            result.touch_press = !r_pen;
            if (r_cur_len != 4'd0) begin
                result.position_valid = 1'b1;
                result.pos_x = {r_store[0], r_store[1]};
                result.pos_y = {r_store[2], r_store[3]};
            end else begin
                result.touch_release = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_HUNT;
            r_cur_id   <= 4'd0;
            r_cur_len  <= 4'd0;
            r_byte_pos <= 4'd0;
            r_sum      <= 8'd0;
            r_pen      <= 1'b0;
        end else begin
            r_phase    <= n_phase;
            r_cur_id   <= n_cur_id;
            r_cur_len  <= n_cur_len;
            r_byte_pos <= n_byte_pos;
            r_sum      <= n_sum;
            r_pen      <= n_pen;
        end
    end

    // Kept payload bytes; they reset to zero because short frames reuse them.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < KEPT_BYTES; i++) begin
                r_store[i] <= 8'd0;
            end
        end else if (store_wr) begin
            r_store[r_byte_pos[IDX_W-1:0]] <= i_rx_byte;
        end
    end

    // The output register is free when empty or when its event leaves now.
    // An event arriving while the output is held goes to the skid register,
    // which then drains into the output ahead of anything else.
    assign out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_free) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= emit;
            end
        end else if (emit) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            r_out <= r_skid_valid ? r_skid : result;
        end
        if (!out_free && emit) begin
            r_skid <= result;
        end
    end

    assign o_in_stall       = r_skid_valid;
    assign o_out_valid      = r_out_valid;
    assign o_frame_id       = r_out.frame_id;
    assign o_key_valid      = r_out.key_valid;
    assign o_key_code       = r_out.key_code;
    assign o_key_down       = r_out.key_pressed;
    assign o_touch_press    = r_out.touch_press;
    assign o_position_valid = r_out.position_valid;
    assign o_pos_x          = r_out.pos_x;
    assign o_pos_y          = r_out.pos_y;
    assign o_touch_release  = r_out.touch_release;

endmodule

@@ rtl/tkfd_checker.sv @@
// ============================================================================
// Touch/key frame decoder checker
// Port-level assertions on the output channel, bound to the core.
// ============================================================================
`include "assert_macros.svh"

module tkfd_checker
    import tkfd_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [3:0]  o_frame_id,
    input logic        o_key_valid,
    input logic [2:0]  o_key_code,
    input logic        o_key_down,
    input logic        o_touch_press,
    input logic        o_position_valid,
    input logic [15:0] o_pos_x,
    input logic [15:0] o_pos_y,
    input logic        o_touch_release
);

    logic out_held;
    logic key_seen;
    logic key_legal;
    logic other_out;
    logic touch_quiet;
    logic no_pos_out;
    logic pos_clear;

    assign out_held    = o_out_valid && i_out_stall;
    assign key_seen    = o_out_valid && (o_key_valid || o_key_down);
    assign key_legal   = o_key_valid && (o_frame_id == ID_KEY) && (o_key_code <= KC_DOWN);
    assign other_out   = o_out_valid && (o_frame_id != ID_TOUCH);
    assign touch_quiet = !o_touch_press && !o_position_valid && !o_touch_release;
    assign no_pos_out  = o_out_valid && !o_position_valid;
    assign pos_clear   = (o_pos_x == 16'd0) && (o_pos_y == 16'd0)
                      && !(o_frame_id == ID_TOUCH && !o_touch_release);

    // A stalled request stays valid.
    `AST_NEXT(a_out_hold, i_clk, i_rst_n, out_held, o_out_valid)

    // A stalled request keeps its coordinates and id.
    `AST_NEXT(a_out_stable, i_clk, i_rst_n, out_held, $stable({o_pos_x, o_pos_y, o_frame_id}))

    // Key fields only ever come with a key frame and a defined key code.
    `AST_IMPLY(a_key_fields, i_clk, i_rst_n, key_seen, key_legal)

    // Touch fields only come with a touch frame; a frame either carries a
    // position or releases the pen, and coordinates are zero without one.
    `AST_IMPLY(a_touch_fields, i_clk, i_rst_n, other_out, touch_quiet)

    `AST_IMPLY(a_touch_split, i_clk, i_rst_n, no_pos_out, pos_clear)

endmodule

bind touch_key_frame_decoder_core tkfd_checker u_tkfd_checker (.*);
